### src/sptx_pkg.sv
// ----------------------------------------------------------------------------
// sptx_pkg
// Shared widths, register codes, data types and the arctangent table of the
// polar-to-XY region filter.
// ----------------------------------------------------------------------------
package sptx_pkg;

   // field widths
   localparam int RANGE_BITS     = 16;
   localparam int ANGLE_BITS     = 16;
   localparam int INDEX_BITS     = 12;
   localparam int INTEN_BITS     = 16;
   localparam int POINT_BITS     = 17;

   // rotation datapath widths
   localparam int PHASE_BITS     = 32;
   localparam int GAIN_BITS      = 30;
   localparam int FRAC_BITS      = 30;
   localparam int MAG_BITS       = RANGE_BITS + GAIN_BITS;
   localparam int XY_BITS        = MAG_BITS + 3;
   localparam int COORD_BITS     = XY_BITS - FRAC_BITS;
   localparam int CMP_BITS       = ((COORD_BITS > POINT_BITS) ? COORD_BITS : POINT_BITS) + 1;
   localparam int NUM_ITER       = 16;
   localparam int ITER_BITS      = 4;

   // CORDIC gain compensation 0.607252935 in Q30
   localparam logic [GAIN_BITS-1:0] GAIN_Q30 = 30'd652032874;
   localparam int COORD_LIMIT    = 65535;

   // configuration port
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 17;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_ANGLE  = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ANGLE_STEP   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_X_MIN = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_X_MAX = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_Y_MIN = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW_Y_MAX = 3'd5;

   localparam logic signed [POINT_BITS-1:0] RESET_X_MIN = -17'sd1200;
   localparam logic signed [POINT_BITS-1:0] RESET_X_MAX = 17'sd0;
   localparam logic signed [POINT_BITS-1:0] RESET_Y_MIN = -17'sd1000;
   localparam logic signed [POINT_BITS-1:0] RESET_Y_MAX = 17'sd700;

   // beam fields carried alongside the rotation
   typedef struct packed {
      logic [INDEX_BITS-1:0] index;
      logic [INTEN_BITS-1:0] inten;
   } beam_type;

   // rotation vector handed from cell to cell
   typedef struct packed {
      logic signed [XY_BITS-1:0]    x;
      logic signed [XY_BITS-1:0]    y;
      logic signed [PHASE_BITS-1:0] z;
      beam_type                     beam;
   } vec_type;

   // region bounds
   typedef struct packed {
      logic signed [POINT_BITS-1:0] x_min;
      logic signed [POINT_BITS-1:0] x_max;
      logic signed [POINT_BITS-1:0] y_min;
      logic signed [POINT_BITS-1:0] y_max;
   } bounds_type;

   // atan(2^-i) in 2^32-per-turn units
   function automatic logic signed [PHASE_BITS-1:0] atan_entry(input logic [ITER_BITS-1:0] i);
      logic signed [PHASE_BITS-1:0] a;
      case (i)
         4'd0:    a = 32'sh20000000;
         4'd1:    a = 32'sh12E4051E;
         4'd2:    a = 32'sh09FB385B;
         4'd3:    a = 32'sh051111D4;
         4'd4:    a = 32'sh028B0D43;
         4'd5:    a = 32'sh0145D7E1;
         4'd6:    a = 32'sh00A2F61E;
         4'd7:    a = 32'sh00517C55;
         4'd8:    a = 32'sh0028BE53;
         4'd9:    a = 32'sh00145F2F;
         4'd10:   a = 32'sh000A2F98;
         4'd11:   a = 32'sh000517CC;
         4'd12:   a = 32'sh00028BE6;
         4'd13:   a = 32'sh000145F3;
         4'd14:   a = 32'sh0000A2FA;
         4'd15:   a = 32'sh0000517D;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage

### src/sptx_front.sv
// ----------------------------------------------------------------------------
// sptx_front
// Beam angle and scaled range, then quadrant fold into the start vector of
// the rotation chain. Two register stages.
// ----------------------------------------------------------------------------
module sptx_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [sptx_pkg::INDEX_BITS-1:0]       req_beam_index,
   input  logic [sptx_pkg::RANGE_BITS-1:0]       req_range_mm,
   input  logic [sptx_pkg::INTEN_BITS-1:0]       req_beam_intensity,
   input  logic [sptx_pkg::ANGLE_BITS-1:0]       start_angle,
   input  logic [sptx_pkg::ANGLE_BITS-1:0]       angle_step,
   output logic                                  out_valid,
   input  logic                                  out_ready,
   output sptx_pkg::vec_type                     out_vec
);

   localparam int PROD_BITS = sptx_pkg::ANGLE_BITS + sptx_pkg::INDEX_BITS;
   localparam int PAD_BITS  = sptx_pkg::PHASE_BITS - sptx_pkg::ANGLE_BITS;

   logic                                   a_valid_ff, a_valid_in;
   logic [sptx_pkg::ANGLE_BITS-1:0]        angle_ff, angle_in;
   logic [sptx_pkg::MAG_BITS-1:0]          mag_ff, mag_in;
   sptx_pkg::beam_type                     a_beam_ff;
   logic                                   b_valid_ff, b_valid_in;
   sptx_pkg::vec_type                      vec_ff, vec_in;
   logic                                   a_ready, b_ready;
   logic [PROD_BITS-1:0]                   step_prod;
   logic [sptx_pkg::PHASE_BITS-1:0]        phase;
   logic                                   fold;

   // stage ready chain
   assign b_ready   = !b_valid_ff || out_ready;
   assign a_ready   = !a_valid_ff || b_ready;
   assign req_stall = !a_ready;

   // angle and scaled range; drop a beam with no return
   always_comb begin
      step_prod  = PROD_BITS'(req_beam_index) * PROD_BITS'(angle_step);
      angle_in   = start_angle + step_prod[sptx_pkg::ANGLE_BITS-1:0];
      mag_in     = sptx_pkg::MAG_BITS'(req_range_mm) * sptx_pkg::MAG_BITS'(sptx_pkg::GAIN_Q30);
      a_valid_in = req_valid && (req_range_mm != {sptx_pkg::RANGE_BITS{1'b1}});
   end

   // fold the second and third quadrants onto the first and fourth
   always_comb begin
      phase     = {angle_ff, {PAD_BITS{1'b0}}};
      fold      = phase[sptx_pkg::PHASE_BITS-1] ^ phase[sptx_pkg::PHASE_BITS-2];
      vec_in.x  = fold ? -$signed(sptx_pkg::XY_BITS'(mag_ff))
                       :  $signed(sptx_pkg::XY_BITS'(mag_ff));
      vec_in.y  = '0;
      vec_in.z  = fold ? $signed(phase ^ {1'b1, {(sptx_pkg::PHASE_BITS-1){1'b0}}})
                       : $signed(phase);
      vec_in.beam = a_beam_ff;
      b_valid_in  = a_valid_ff;
   end

   // advance stage A
   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= a_valid_in;
      end
      if (a_ready) begin
         angle_ff        <= angle_in;
         mag_ff          <= mag_in;
         a_beam_ff.index <= req_beam_index;
         a_beam_ff.inten <= req_beam_intensity;
      end
   end

   // advance stage B
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (b_ready) begin
         b_valid_ff <= b_valid_in;
      end
      if (b_ready) begin
         vec_ff <= vec_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_vec   = vec_ff;

endmodule

### src/sptx_cordic_cell.sv
// ----------------------------------------------------------------------------
// sptx_cordic_cell
// One CORDIC rotation step with its own register stage; the step number
// selects shift and arctangent.
// ----------------------------------------------------------------------------
module sptx_cordic_cell (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [sptx_pkg::ITER_BITS-1:0]   iter,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  sptx_pkg::vec_type                in_vec,
   output logic                             out_valid,
   input  logic                             out_ready,
   output sptx_pkg::vec_type                out_vec
);

   logic                               valid_ff;
   sptx_pkg::vec_type                  vec_ff, vec_in;
   logic signed [sptx_pkg::XY_BITS-1:0]    xs, ys;
   logic signed [sptx_pkg::PHASE_BITS-1:0] atan;

   assign in_ready = !valid_ff || out_ready;

   // rotate toward zero residual angle
   always_comb begin
      xs   = in_vec.x >>> iter;
      ys   = in_vec.y >>> iter;
      atan = sptx_pkg::atan_entry(iter);
      vec_in.beam = in_vec.beam;
      if (!in_vec.z[sptx_pkg::PHASE_BITS-1]) begin
         vec_in.x = in_vec.x - ys;
         vec_in.y = in_vec.y + xs;
         vec_in.z = in_vec.z - atan;
      end else begin
         vec_in.x = in_vec.x + ys;
         vec_in.y = in_vec.y - xs;
         vec_in.z = in_vec.z + atan;
      end
   end

   // hold while the neighbor is full
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready) begin
         vec_ff <= vec_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_vec   = vec_ff;

endmodule

### src/sptx_window.sv
// ----------------------------------------------------------------------------
// sptx_window
// Round coordinates to millimetres, test them against the region, negate
// and clamp, and hold the result in the output register.
// ----------------------------------------------------------------------------
module sptx_window (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  in_valid,
   output logic                                  in_ready,
   input  sptx_pkg::vec_type                     in_vec,
   input  sptx_pkg::bounds_type                  bounds,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [sptx_pkg::POINT_BITS-1:0] rsp_point_x,
   output logic signed [sptx_pkg::POINT_BITS-1:0] rsp_point_y,
   output logic [sptx_pkg::INTEN_BITS-1:0]       rsp_point_intensity,
   output logic [sptx_pkg::INDEX_BITS-1:0]       rsp_point_beam
);

   localparam int NEG_BITS = sptx_pkg::CMP_BITS + 1;
   localparam logic signed [sptx_pkg::XY_BITS-1:0] ROUND_HALF =
      {{(sptx_pkg::XY_BITS - sptx_pkg::FRAC_BITS){1'b0}}, 1'b1,
       {(sptx_pkg::FRAC_BITS - 1){1'b0}}};
   localparam logic signed [NEG_BITS-1:0] LIMIT_POS = NEG_BITS'(sptx_pkg::COORD_LIMIT);
   localparam logic signed [NEG_BITS-1:0] LIMIT_NEG = -LIMIT_POS;

   logic                                       r_valid_ff;
   logic signed [sptx_pkg::COORD_BITS-1:0]     rx_ff, ry_ff;
   sptx_pkg::beam_type                         r_beam_ff;
   logic signed [sptx_pkg::XY_BITS-1:0]        x_sum, y_sum, x_sh, y_sh;
   logic                                       r_ready, out_load, in_window;
   logic signed [sptx_pkg::CMP_BITS-1:0]       cx, cy;
   logic signed [NEG_BITS-1:0]                 nx, ny, kx, ky;
   logic                                       rsp_valid_ff, rsp_valid_in;
   logic signed [sptx_pkg::POINT_BITS-1:0]     px_ff, py_ff;
   logic [sptx_pkg::INTEN_BITS-1:0]            pi_ff;
   logic [sptx_pkg::INDEX_BITS-1:0]            pb_ff;

   assign out_load = !rsp_valid_ff || !rsp_stall;
   assign r_ready  = !r_valid_ff || out_load;
   assign in_ready = r_ready;

   // round half up to millimetres
   always_comb begin
      x_sum = in_vec.x + ROUND_HALF;
      y_sum = in_vec.y + ROUND_HALF;
      x_sh  = x_sum >>> sptx_pkg::FRAC_BITS;
      y_sh  = y_sum >>> sptx_pkg::FRAC_BITS;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else if (r_ready) begin
         r_valid_ff <= in_valid;
      end
      if (r_ready) begin
         rx_ff     <= x_sh[sptx_pkg::COORD_BITS-1:0];
         ry_ff     <= y_sh[sptx_pkg::COORD_BITS-1:0];
         r_beam_ff <= in_vec.beam;
      end
   end

   // region test, then negate and clamp
   always_comb begin
      cx = sptx_pkg::CMP_BITS'(rx_ff);
      cy = sptx_pkg::CMP_BITS'(ry_ff);
      in_window = (cx >= sptx_pkg::CMP_BITS'(bounds.x_min)) &&
                  (cx <= sptx_pkg::CMP_BITS'(bounds.x_max)) &&
                  (cy >= sptx_pkg::CMP_BITS'(bounds.y_min)) &&
                  (cy <= sptx_pkg::CMP_BITS'(bounds.y_max));
      nx = -NEG_BITS'(cx);
      ny = -NEG_BITS'(cy);
      kx = (nx > LIMIT_POS) ? LIMIT_POS : ((nx < LIMIT_NEG) ? LIMIT_NEG : nx);
      ky = (ny > LIMIT_POS) ? LIMIT_POS : ((ny < LIMIT_NEG) ? LIMIT_NEG : ny);
      rsp_valid_in = r_valid_ff && in_window;
   end

   // load the output register when it is empty or being taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load && rsp_valid_in) begin
         px_ff <= kx[sptx_pkg::POINT_BITS-1:0];
         py_ff <= ky[sptx_pkg::POINT_BITS-1:0];
         pi_ff <= r_beam_ff.inten;
         pb_ff <= r_beam_ff.index;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_point_x         = px_ff;
   assign rsp_point_y         = py_ff;
   assign rsp_point_intensity = pi_ff;
   assign rsp_point_beam      = pb_ff;

endmodule

### src/scan_polar_to_xy_roi_filter_core.sv
// Pipeline: an accepted beam passes 2 front stages, 16 rotation cells, 1 rounding
// stage and 1 output register on its way to its point.
// Throughput: one beam per cycle; each stage moves on when its successor has room.
// Dropped beams (no return or outside the region) leave bubbles that later beams fill.
// Reset: synchronous, active high; empties every stage and restores register defaults.
// ----------------------------------------------------------------------------
// scan_polar_to_xy_roi_filter_core
// Polar-to-XY conversion of lidar beams through a chain of CORDIC cells,
// with a rectangular region filter on the result.
// ----------------------------------------------------------------------------
module scan_polar_to_xy_roi_filter_core (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      req_valid,
   output logic                                      req_stall,
   input  logic [sptx_pkg::INDEX_BITS-1:0]           req_beam_index,
   input  logic [sptx_pkg::RANGE_BITS-1:0]           req_range_mm,
   input  logic [sptx_pkg::INTEN_BITS-1:0]           req_beam_intensity,
   output logic                                      rsp_valid,
   input  logic                                      rsp_stall,
   output logic signed [sptx_pkg::POINT_BITS-1:0]    rsp_point_x,
   output logic signed [sptx_pkg::POINT_BITS-1:0]    rsp_point_y,
   output logic [sptx_pkg::INTEN_BITS-1:0]           rsp_point_intensity,
   output logic [sptx_pkg::INDEX_BITS-1:0]           rsp_point_beam,
   input  logic                                      csr_wr_en,
   input  logic [sptx_pkg::CSR_INDEX_BITS-1:0]       csr_index,
   input  logic [sptx_pkg::CSR_DATA_BITS-1:0]        csr_wdata
);

   logic [sptx_pkg::ANGLE_BITS-1:0] start_angle_ff;
   logic [sptx_pkg::ANGLE_BITS-1:0] angle_step_ff;
   sptx_pkg::bounds_type            bounds_ff;

   logic                            chain_valid [0:sptx_pkg::NUM_ITER];
   logic                            chain_ready [0:sptx_pkg::NUM_ITER];
   sptx_pkg::vec_type               chain_vec   [0:sptx_pkg::NUM_ITER];

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_angle_ff  <= '0;
         angle_step_ff   <= '0;
         bounds_ff.x_min <= sptx_pkg::RESET_X_MIN;
         bounds_ff.x_max <= sptx_pkg::RESET_X_MAX;
         bounds_ff.y_min <= sptx_pkg::RESET_Y_MIN;
         bounds_ff.y_max <= sptx_pkg::RESET_Y_MAX;
      end else if (csr_wr_en) begin
         case (csr_index)
            sptx_pkg::CSR_START_ANGLE:  start_angle_ff  <= csr_wdata[sptx_pkg::ANGLE_BITS-1:0];
            sptx_pkg::CSR_ANGLE_STEP:   angle_step_ff   <= csr_wdata[sptx_pkg::ANGLE_BITS-1:0];
            sptx_pkg::CSR_WINDOW_X_MIN: bounds_ff.x_min <= $signed(csr_wdata);
            sptx_pkg::CSR_WINDOW_X_MAX: bounds_ff.x_max <= $signed(csr_wdata);
            sptx_pkg::CSR_WINDOW_Y_MIN: bounds_ff.y_min <= $signed(csr_wdata);
            sptx_pkg::CSR_WINDOW_Y_MAX: bounds_ff.y_max <= $signed(csr_wdata);
            default: begin
            end
         endcase
      end
   end

   // angle, scaled range and quadrant fold
   sptx_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_beam_index     (req_beam_index),
      .req_range_mm       (req_range_mm),
      .req_beam_intensity (req_beam_intensity),
      .start_angle        (start_angle_ff),
      .angle_step         (angle_step_ff),
      .out_valid          (chain_valid[0]),
      .out_ready          (chain_ready[0]),
      .out_vec            (chain_vec[0])
   );

   // rotation cells, one step each
   for (genvar k = 0; k < sptx_pkg::NUM_ITER; k++) begin : g_cell
      sptx_cordic_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .iter      (sptx_pkg::ITER_BITS'(k)),
         .in_valid  (chain_valid[k]),
         .in_ready  (chain_ready[k]),
         .in_vec    (chain_vec[k]),
         .out_valid (chain_valid[k+1]),
         .out_ready (chain_ready[k+1]),
         .out_vec   (chain_vec[k+1])
      );
   end

   // rounding, region test and output register
   sptx_window u_window (
      .clock               (clock),
      .reset               (reset),
      .in_valid            (chain_valid[sptx_pkg::NUM_ITER]),
      .in_ready            (chain_ready[sptx_pkg::NUM_ITER]),
      .in_vec              (chain_vec[sptx_pkg::NUM_ITER]),
      .bounds              (bounds_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_point_x         (rsp_point_x),
      .rsp_point_y         (rsp_point_y),
      .rsp_point_intensity (rsp_point_intensity),
      .rsp_point_beam      (rsp_point_beam)
   );

`ifndef SYNTHESIS
   // input backs up only when every stage is full behind a stalled result
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled with room in the pipeline");

   // a negated coordinate never leaves the clamp range
   a_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_point_x != 17'sh10000) && (rsp_point_y != 17'sh10000)))
      else $error("point coordinate outside clamp range");

   // reset empties the output register
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");
`endif

endmodule
